// File: src/gdr_pkg.sv
// ---------------------------------------------------------------------------
// gdr_pkg: shared constants for the GDSII real to IEEE double converter
// Field widths and the fixed numbers of both floating-point formats.
// ---------------------------------------------------------------------------
package gdr_pkg;
    localparam int WordW     = 64;
    localparam int MantW     = 56;
    localparam int ExpW      = 7;
    localparam int FracW     = 52;
    localparam int PosW      = 6;
    localparam int IeeeExpW  = 11;
    // Bias applied to the binary exponent: 1023 - 4*(64+14).
    localparam int ExpOffset = 1023 - 4 * (64 + 14);

    typedef logic [WordW-1:0] word_t;
endpackage

// File: src/gdr_stream_if.sv
// ---------------------------------------------------------------------------
// gdr_stream_if: valid/ready channel carrying one 64-bit word
// A transfer happens at a clock edge where valid and ready are both high.
// ---------------------------------------------------------------------------
interface gdr_stream_if
    import gdr_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/gdr_convert.sv
// ---------------------------------------------------------------------------
// gdr_convert: combinational GDSII real to binary64 conversion
// Normalizes the mantissa, rounds to nearest even and packs the fields.
// ---------------------------------------------------------------------------
module gdr_convert
    import gdr_pkg::*;
(
    input  word_t gdsii_word,
    output word_t ieee_bits
);
    logic              sign;
    logic [ExpW-1:0]   expo;
    logic [MantW-1:0]  mant;
    logic [PosW-1:0]   top;
    logic [MantW-1:0]  norm;
    logic [FracW+1:0]  q;
    logic              guard;
    logic              sticky;
    logic              round_up;
    logic [FracW+1:0]  q_rnd;
    logic              carry;
    logic [IeeeExpW:0] ex;

    assign sign = gdsii_word[63];
    assign expo = gdsii_word[MantW +: ExpW];
    assign mant = gdsii_word[MantW-1:0];

    // Leading-one position, found by a priority scan.
    always_comb
    begin
        top = '0;
        for (int i = 0; i < MantW; i++)
        begin
            if (mant[i])
            begin
                top = PosW'(i);
            end
        end
    end

    // Shift the leading one to bit 55; the low three bits are round bits.
    assign norm   = mant << (PosW'(MantW - 1) - top);
    assign q      = {1'b0, norm[MantW-1 -: FracW+1]};
    assign guard  = norm[2];
    assign sticky = |norm[1:0];
    assign round_up = guard && (sticky || q[0]);
    assign q_rnd  = q + (FracW+2)'(round_up);
    assign carry  = q_rnd[FracW+1];

    // Biased exponent: top + 4*e + offset, plus one on rounding carry.
    assign ex = (IeeeExpW+1)'(top) + {(IeeeExpW+1-ExpW-2)'(0), expo, 2'b00}
              + (IeeeExpW+1)'(ExpOffset) + (IeeeExpW+1)'(carry);

    always_comb
    begin
        if (mant == '0)
        begin
            ieee_bits = {sign, (WordW-1)'(0)};
        end
        else
        begin
            ieee_bits = {sign, ex[IeeeExpW-1:0],
                         carry ? q_rnd[FracW:1] : q_rnd[FracW-1:0]};
        end
    end
endmodule

// File: src/gdsii_real_to_ieee_double_core.sv
// ---------------------------------------------------------------------------
// gdsii_real_to_ieee_double_core: GDSII eight-byte real to IEEE binary64
// Input register, one combinational conversion, output register.
// ---------------------------------------------------------------------------
//  channel  | dir | payload     | meaning
//  in_ch    | in  | gdsii_word  | raw GDSII real, first byte in 63..56
//  out_ch   | out | ieee_bits   | binary64 bit pattern
//
// One item is accepted per cycle while the output is not stalled. A result
// passes through the input register, the conversion and the output register
// before it is presented. Each register stage holds when the stage after it
// is full and stalled. Reset clears both valid flags; payload is not reset.
module gdsii_real_to_ieee_double_core
    import gdr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    gdr_stream_if.sink   in_ch,
    gdr_stream_if.source out_ch
);
    logic  in_vld_reg;
    word_t in_data_reg;
    logic  out_vld_reg;
    word_t out_data_reg;
    word_t conv;
    logic  out_adv;
    logic  in_adv;

    assign out_adv      = !out_vld_reg || out_ch.ready;
    assign in_adv       = !in_vld_reg || out_adv;
    assign in_ch.ready  = in_adv;
    assign out_ch.valid = out_vld_reg;
    assign out_ch.data  = out_data_reg;

    gdr_convert u_conv (.gdsii_word(in_data_reg), .ieee_bits(conv));

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_vld_reg <= in_ch.valid;
            end
            if (out_adv)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_adv && in_ch.valid)
        begin
            in_data_reg <= in_ch.data;
        end
        if (out_adv && in_vld_reg)
        begin
            out_data_reg <= conv;
        end
    end
endmodule

// File: src/gdr_checker.sv
// ---------------------------------------------------------------------------
// gdr_checker: port-level assertions for the converter
// Checks stall behavior, zero handling and result arrival seen at the ports.
// ---------------------------------------------------------------------------
module gdr_checker
    import gdr_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input word_t in_data,
    input logic  out_valid,
    input logic  out_ready,
    input word_t out_data
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Input is never refused while the output side is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A zero-mantissa transfer into an empty pipeline yields signed zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data[MantW-1:0] == '0 && !out_valid
        && !$past(in_valid && in_ready)
        |=> ##1 out_valid && out_data == {$past(in_data[63], 2), 63'd0} || !rst_n)
        else $error("zero mantissa not converted to signed zero");

    // A transfer in while the output side is empty is followed by a valid result.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("result missing");
endmodule

bind gdsii_real_to_ieee_double_core gdr_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
